// ----- sv/rtmf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtmf_pkg
// Shared constants and types of the ratio trimmed-mean filter.
// ----------------------------------------------------------------------------
package rtmf_pkg;
	localparam int BLOCK_LEN  = 15;
	localparam int KEEP_COUNT = 5;
	localparam int RING_LEN   = 15;
	localparam int KEEP       = (KEEP_COUNT > BLOCK_LEN) ? BLOCK_LEN : KEEP_COUNT;
	localparam int START      = (BLOCK_LEN - KEEP) / 2;
	localparam int BIW        = $clog2(BLOCK_LEN + 1);
	localparam int RIW        = $clog2(RING_LEN + 1);
	localparam int BAW        = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
	localparam int RAW        = (RING_LEN > 1) ? $clog2(RING_LEN) : 1;
	localparam int SUMW       = 40;

	// reciprocal multiply for the division of the window sum by KEEP
	localparam int     TRW      = 32 + $clog2(KEEP);
	localparam int     TRIM_SH  = TRW + $clog2(KEEP);
	localparam int     TMW      = TRW + 1;
	localparam longint TRIM_MUL = ((64'sd1 <<< TRIM_SH) + KEEP - 1) / KEEP;
	localparam int     TNCH     = (TRW + 15) / 16;
	localparam int     TMAGW    = 16 * TNCH;
	localparam int     TCW      = $clog2(TNCH + 1);
	localparam int     TACCW    = TMAGW + TMW;

	typedef struct packed {
		logic signed [15:0] chan_a_high;
		logic signed [15:0] chan_a_low;
		logic signed [15:0] chan_b_high;
		logic signed [15:0] chan_b_low;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] sample_ratio;
		logic               block_done;
		logic signed [31:0] trimmed_mean;
		logic signed [31:0] filtered_ratio;
	} out_item_t;

	typedef struct packed {
		logic              start;
		logic signed [SUMW-1:0] dividend;
		logic        [SUMW-1:0] divisor;
	} div_req_t;

	function automatic logic signed [31:0] sat32(input logic signed [SUMW:0] v);
		logic signed [31:0] r;
		if (v > $signed({{(SUMW-30){1'b0}}, 31'h7FFFFFFF}))
			r = 32'sh7FFFFFFF;
		else if (v < -$signed({{(SUMW-31){1'b0}}, 32'h80000000}))
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction
endpackage

// ----- sv/rtmf_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtmf_if
// Valid/ready channel carrying one item.
// ----------------------------------------------------------------------------
interface rtmf_in_if;
	import rtmf_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rtmf_out_if;
	import rtmf_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- sv/ratio_trimmed_mean_filter.sv -----
`timescale 1ns / 1ps
// An item that does not close a block runs the 40-step ratio divider from input
// accept to output valid; when the B amplitude is zero the divider is skipped.
// The item that closes a block also runs a sort through the block memory, trim,
// ring sum and a 40-step divider pass for the ring average.
// One item at a time; next item accepted the cycle after the result is taken.
// Reset clears indexes, fill count and last values; memories are not cleared.
// ----------------------------------------------------------------------------
// ratio_trimmed_mean_filter
// Top level: input handshake, core sequencer and output register.
// ----------------------------------------------------------------------------
module ratio_trimmed_mean_filter (
	input  logic clk,
	input  logic arst_n,
	rtmf_in_if.sink    in_ch,
	rtmf_out_if.source out_ch
);
	import rtmf_pkg::*;

	logic      core_idle;
	logic      core_finish;
	out_item_t core_res;
	logic      busy_q;
	logic      ovalid_q;
	out_item_t odata_q;
	logic      take;

	assign in_ch.ready = !busy_q && !ovalid_q && core_idle;
	assign take        = in_ch.valid && in_ch.ready;

	rtmf_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (take),
		.item   (in_ch.data),
		.idle   (core_idle),
		.finish (core_finish),
		.result (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (take) busy_q <= 1'b1;
			else if (core_finish) busy_q <= 1'b0;
			if (core_finish) ovalid_q <= 1'b1;
			else if (out_ch.ready) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_finish) odata_q <= core_res;
	end

	assign out_ch.valid = ovalid_q;
	assign out_ch.data  = odata_q;

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !take) else $error("item taken while busy");
	a_finish_busy: assert property (@(posedge clk) disable iff (!arst_n)
		core_finish |-> busy_q) else $error("finish without item");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q |-> !core_finish) else $error("result overwritten");
endmodule

// ----- sv/rtmf_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtmf_div
// Restoring signed divider, one quotient bit a cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module rtmf_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rtmf_pkg::div_req_t              req,
	output logic                            done,
	output logic signed [rtmf_pkg::SUMW:0]  quotient
);
	import rtmf_pkg::*;

	localparam int CW = $clog2(SUMW + 1);

	logic [SUMW-1:0] num_q;
	logic [SUMW-1:0] den_q;
	logic [SUMW-1:0] quo_q;
	logic [SUMW:0]   rem_q;
	logic            neg_q;
	logic [CW-1:0]   cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [SUMW:0]   trial;
	logic [SUMW:0]   shifted;

	always_comb begin
		shifted = {rem_q[SUMW-1:0], num_q[SUMW-1]};
		trial   = shifted - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(SUMW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend[SUMW-1] ? -req.dividend : req.dividend;
			den_q <= req.divisor;
			neg_q <= req.dividend[SUMW-1];
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[SUMW-2:0], 1'b0};
			if (!trial[SUMW]) begin
				rem_q <= trial;
				quo_q <= {quo_q[SUMW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[SUMW-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
endmodule

// ----- sv/rtmf_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtmf_core
// Sequencer around the block and ring memories: ratio, sort, trim, average.
// ----------------------------------------------------------------------------
module rtmf_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  rtmf_pkg::in_item_t      item,
	output logic                    idle,
	output logic                    finish,
	output rtmf_pkg::out_item_t     result
);
	import rtmf_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_RDIV  = 4'd1;
	localparam logic [3:0] ST_RWAIT = 4'd2;
	localparam logic [3:0] ST_SRDI  = 4'd3;
	localparam logic [3:0] ST_SRDJ  = 4'd4;
	localparam logic [3:0] ST_SCMP  = 4'd5;
	localparam logic [3:0] ST_SUM   = 4'd6;
	localparam logic [3:0] ST_TDIV  = 4'd7;
	localparam logic [3:0] ST_TWAIT = 4'd8;
	localparam logic [3:0] ST_RSUM  = 4'd9;
	localparam logic [3:0] ST_FDIV  = 4'd10;
	localparam logic [3:0] ST_FWAIT = 4'd11;
	localparam logic [3:0] ST_DONE  = 4'd12;
	localparam logic [3:0] ST_SLDI  = 4'd13;

	localparam logic [TMW-1:0] TRIM_MUL_V = TMW'(TRIM_MUL);

	logic signed [31:0] blk_mem [BLOCK_LEN];
	logic signed [31:0] ring_mem [RING_LEN];
	logic signed [31:0] blk_rd_s1;
	logic signed [31:0] ring_rd_s1;
	logic [BAW-1:0]     blk_ra;
	logic               blk_we;
	logic [BAW-1:0]     blk_wa;
	logic signed [31:0] blk_wd;
	logic               ring_we;
	logic [RAW-1:0]     ring_wa;
	logic signed [31:0] ring_wd;
	logic [RAW-1:0]     ring_ra;

	logic [3:0]         state_q;
	logic [BIW-1:0]     bidx_q;
	logic [RIW-1:0]     ridx_q;
	logic [RIW-1:0]     fill_q;
	logic signed [31:0] trim_q;
	logic signed [31:0] filt_q;
	logic signed [31:0] ratio_q;
	logic signed [16:0] amp_a_q;
	logic signed [16:0] amp_b_q;
	logic [BIW-1:0]     i_q;
	logic [BIW-1:0]     j_q;
	logic signed [31:0] vi_q;
	logic signed [SUMW-1:0] sum_q;
	logic               rd_ok_q;
	logic               swap_q;
	logic [BAW-1:0]     swap_a_q;
	logic signed [31:0] swap_d_q;
	logic [TMAGW-1:0]   tmag_q;
	logic               tneg_q;
	logic [TACCW-1:0]   tacc_q;
	logic [TCW-1:0]     tcnt_q;
	logic [15+TMW:0]    tprod;
	logic [SUMW:0]      tmag_ext;
	logic signed [31:0] trim_val;
	div_req_t           dreq;
	logic               ddone;
	logic signed [SUMW:0] dquo;

	always_ff @(posedge clk) begin
		if (blk_we) blk_mem[blk_wa] <= blk_wd;
		blk_rd_s1 <= blk_mem[blk_ra];
		if (ring_we) ring_mem[ring_wa] <= ring_wd;
		ring_rd_s1 <= ring_mem[ring_ra];
	end

	rtmf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (dreq),
		.done     (ddone),
		.quotient (dquo)
	);

	always_comb begin
		tprod    = {{TMW{1'b0}}, tmag_q[TMAGW-1 -: 16]} * {16'h0000, TRIM_MUL_V};
		tmag_ext = {{(SUMW-31){1'b0}}, tacc_q[TRIM_SH +: 32]};
		trim_val = sat32(tneg_q ? -$signed(tmag_ext) : $signed(tmag_ext));
	end

	always_comb begin
		dreq = '{start: 1'b0, dividend: '0, divisor: '0};
		blk_we = 1'b0;
		blk_wa = bidx_q[BAW-1:0];
		blk_wd = ratio_q;
		blk_ra = i_q[BAW-1:0];
		ring_we = 1'b0;
		ring_wa = ridx_q[RAW-1:0];
		ring_wd = trim_q;
		ring_ra = i_q[RAW-1:0];
		unique case (state_q)
			ST_RDIV: begin
				dreq.start    = (amp_b_q != 0);
				dreq.dividend = amp_b_q[16] ? -SUMW'($signed({amp_a_q, 16'h0000}))
					: SUMW'($signed({amp_a_q, 16'h0000}));
				dreq.divisor  = amp_b_q[16] ? SUMW'(-amp_b_q) : SUMW'(amp_b_q);
			end
			ST_SLDI: blk_ra = j_q[BAW-1:0];
			ST_SRDJ: blk_ra = j_q[BAW-1:0];
			ST_SCMP: begin
				if (vi_q > blk_rd_s1) begin
					blk_we = 1'b1;
					blk_wa = i_q[BAW-1:0];
					blk_wd = blk_rd_s1;
				end
			end
			ST_FDIV: begin
				dreq.start    = 1'b1;
				dreq.dividend = sum_q;
				dreq.divisor  = SUMW'(fill_q);
			end
			ST_DONE: blk_we = 1'b1;
			default: ;
		endcase
		if (swap_q) begin
			blk_we = 1'b1;
			blk_wa = swap_a_q;
			blk_wd = swap_d_q;
		end
		if (state_q == ST_TWAIT && tcnt_q == '0) begin
			ring_we = 1'b1;
			ring_wd = trim_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bidx_q  <= '0;
			ridx_q  <= '0;
			fill_q  <= '0;
			trim_q  <= '0;
			filt_q  <= '0;
			swap_q  <= 1'b0;
		end else begin
			swap_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_RDIV;
				end
				ST_RDIV: begin
					if (amp_b_q == 0) begin
						ratio_q <= amp_a_q[16] ? 32'sh80000000 : 32'sh7FFFFFFF;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_RWAIT;
					end
				end
				ST_RWAIT: begin
					if (ddone) begin
						ratio_q <= sat32(dquo);
						state_q <= ST_DONE;
					end
				end
				ST_SRDI: state_q <= ST_SLDI;
				ST_SLDI: begin
					vi_q    <= blk_rd_s1;
					state_q <= ST_SCMP;
				end
				ST_SRDJ: state_q <= ST_SCMP;
				ST_SCMP: begin
					if (vi_q > blk_rd_s1) begin
						swap_q   <= 1'b1;
						swap_a_q <= j_q[BAW-1:0];
						swap_d_q <= vi_q;
						vi_q     <= blk_rd_s1;
					end
					if (j_q == BIW'(BLOCK_LEN - 1)) begin
						if (i_q == BIW'(BLOCK_LEN - 2)) begin
							i_q     <= BIW'(START);
							sum_q   <= '0;
							state_q <= ST_SUM;
							rd_ok_q <= 1'b0;
						end else begin
							i_q     <= i_q + 1'b1;
							j_q     <= i_q + BIW'(2);
							state_q <= ST_SRDI;
						end
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_SRDJ;
					end
				end
				ST_SUM: begin
					rd_ok_q <= 1'b1;
					if (rd_ok_q) sum_q <= sum_q + SUMW'(blk_rd_s1);
					if (i_q == BIW'(START + KEEP)) begin
						state_q <= ST_TDIV;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_TDIV: begin
					tmag_q  <= TMAGW'(sum_q[SUMW-1] ? -sum_q : sum_q);
					tneg_q  <= sum_q[SUMW-1];
					tacc_q  <= '0;
					tcnt_q  <= TCW'(TNCH);
					state_q <= ST_TWAIT;
				end
				ST_TWAIT: begin
					if (tcnt_q != '0) begin
						tacc_q <= {tacc_q[TACCW-17:0], 16'h0000} + TACCW'(tprod);
						tmag_q <= {tmag_q[TMAGW-17:0], 16'h0000};
						tcnt_q <= tcnt_q - 1'b1;
					end else begin
						trim_q  <= trim_val;
						ridx_q  <= (ridx_q == RIW'(RING_LEN - 1)) ? '0 : ridx_q + 1'b1;
						if (fill_q != RIW'(RING_LEN)) fill_q <= fill_q + 1'b1;
						i_q     <= '0;
						sum_q   <= '0;
						rd_ok_q <= 1'b0;
						state_q <= ST_RSUM;
					end
				end
				ST_RSUM: begin
					rd_ok_q <= 1'b1;
					if (rd_ok_q) sum_q <= sum_q + SUMW'(ring_rd_s1);
					if (i_q == BIW'(fill_q)) begin
						state_q <= ST_FDIV;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_FDIV: state_q <= ST_FWAIT;
				ST_FWAIT: begin
					if (ddone) begin
						filt_q  <= sat32(dquo);
						state_q <= ST_IDLE;
					end
				end
				ST_DONE: begin
					if (bidx_q == BIW'(BLOCK_LEN - 1)) begin
						bidx_q  <= '0;
						i_q     <= '0;
						j_q     <= BIW'(1);
						state_q <= ST_SRDI;
					end else begin
						bidx_q  <= bidx_q + 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && state_q == ST_IDLE) begin
			amp_a_q <= 17'(item.chan_a_high) - 17'(item.chan_a_low);
			amp_b_q <= 17'(item.chan_b_high) - 17'(item.chan_b_low);
		end
	end

	assign idle   = (state_q == ST_IDLE);
	assign finish = (state_q == ST_DONE && bidx_q != BIW'(BLOCK_LEN - 1))
		|| (state_q == ST_FWAIT && ddone);
	assign result = '{sample_ratio: ratio_q,
		block_done: (state_q == ST_FWAIT),
		trimmed_mean: trim_q,
		filtered_ratio: (state_q == ST_FWAIT) ? sat32(dquo) : filt_q};
endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ratio trimmed-mean filter: random peak items
// are pushed in with bursty timing, results are checked against a predicted
// ratio, block trimmed mean and ring average, with random output stalls.
// ----------------------------------------------------------------------------
module tb;
	import rtmf_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 600;

	logic clk;
	logic arst_n;

	rtmf_in_if  in_ch ();
	rtmf_out_if out_ch ();

	ratio_trimmed_mean_filter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	in_item_t  pending_items[$];
	out_item_t expected_results[$];
	int        error_count;
	int        idle_cycles;
	bit        stimulus_done;

	logic signed [31:0] block_ratios[BLOCK_LEN];
	logic signed [31:0] mean_history[RING_LEN];
	int                 block_pos;
	int                 history_pos;
	int                 history_fill;
	logic signed [31:0] held_trimmed;
	logic signed [31:0] held_filtered;

	function automatic logic signed [31:0] clamp32(input longint v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647)
			r = 32'sh7FFFFFFF;
		else if (v < -64'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] peak_ratio(input in_item_t it);
		longint amp_a;
		longint amp_b;
		logic signed [31:0] r;
		amp_a = longint'(it.chan_a_high) - longint'(it.chan_a_low);
		amp_b = longint'(it.chan_b_high) - longint'(it.chan_b_low);
		if (amp_b == 0)
			r = (amp_a >= 0) ? 32'sh7FFFFFFF : 32'sh80000000;
		else
			r = clamp32((amp_a * 65536) / amp_b);
		return r;
	endfunction

	task automatic predict_filter(input in_item_t it);
		out_item_t          res;
		logic signed [31:0] sorted[BLOCK_LEN];
		logic signed [31:0] t;
		longint             acc;
		res.sample_ratio = peak_ratio(it);
		res.block_done = 1'b0;
		block_ratios[block_pos] = res.sample_ratio;
		block_pos++;
		if (block_pos >= BLOCK_LEN) begin
			block_pos = 0;
			sorted = block_ratios;
			for (int i = 0; i < BLOCK_LEN - 1; i++)
				for (int j = i + 1; j < BLOCK_LEN; j++)
					if (sorted[i] > sorted[j]) begin
						t = sorted[i];
						sorted[i] = sorted[j];
						sorted[j] = t;
					end
			acc = 0;
			for (int k = 0; k < KEEP; k++)
				acc += longint'(sorted[START + k]);
			held_trimmed = clamp32(acc / KEEP);
			mean_history[history_pos] = held_trimmed;
			history_pos = (history_pos + 1) % RING_LEN;
			if (history_fill < RING_LEN)
				history_fill++;
			acc = 0;
			for (int k = 0; k < history_fill; k++)
				acc += longint'(mean_history[k]);
			held_filtered = clamp32(acc / history_fill);
			res.block_done = 1'b1;
		end
		res.trimmed_mean = held_trimmed;
		res.filtered_ratio = held_filtered;
		expected_results.push_back(res);
	endtask

	function automatic logic [15:0] edge_code(input int sel);
		logic [15:0] c;
		case (sel)
			0: c = 16'h8000;
			1: c = 16'h7FFF;
			2: c = 16'h0000;
			3: c = 16'hFFFF;
			default: c = 16'($urandom);
		endcase
		return c;
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		int base_a;
		int base_b;
		case ($urandom_range(9))
			0, 1, 2, 3, 4: begin
				base_a = $urandom_range(30000) - 15000;
				base_b = $urandom_range(30000) - 15000;
				it.chan_a_low = 16'(base_a);
				it.chan_a_high = 16'(base_a + $urandom_range(2000));
				it.chan_b_low = 16'(base_b);
				it.chan_b_high = 16'(base_b + $urandom_range(2000));
			end
			5: begin
				it = '{default: '0};
				it.chan_a_high = 16'($urandom);
				it.chan_a_low = 16'($urandom);
				it.chan_b_high = 16'($urandom);
				it.chan_b_low = it.chan_b_high;
			end
			6: begin
				it.chan_a_high = edge_code($urandom_range(4));
				it.chan_a_low = edge_code($urandom_range(4));
				it.chan_b_high = edge_code($urandom_range(4));
				it.chan_b_low = edge_code($urandom_range(4));
			end
			7: begin
				it.chan_a_high = 16'($urandom);
				it.chan_a_low = 16'($urandom);
				it.chan_b_high = 16'($urandom_range(3));
				it.chan_b_low = 16'($urandom_range(3));
			end
			default: it = in_item_t'({$urandom, $urandom});
		endcase
		return it;
	endfunction

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// driver
	int  burst_left;
	int  gap_left;
	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		burst_left = 0;
		gap_left = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (in_ch.valid && !in_ch.ready) begin
		end else if (gap_left > 0) begin
			in_ch.valid <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (pending_items.size() > 0) begin
			in_ch.data <= pending_items[0];
			predict_filter(pending_items.pop_front());
			in_ch.valid <= 1'b1;
			if (burst_left == 0) begin
				burst_left <= $urandom_range(12);
				gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(400);
			end else begin
				burst_left <= burst_left - 1;
			end
		end else begin
			in_ch.valid <= 1'b0;
		end
	end

	// monitor and receiver stall
	int stall_phase;
	initial begin
		out_ch.ready = 1'b0;
		stall_phase = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_phase <= 0;
		end else begin
			stall_phase <= (stall_phase + 1) % 4096;
			if (stall_phase < 1024)
				out_ch.ready <= 1'b1;
			else if (stall_phase < 3072)
				out_ch.ready <= ($urandom_range(3) != 0);
			else
				out_ch.ready <= ($urandom_range(9) == 0);
			if (out_ch.valid && out_ch.ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result item: %p", out_ch.data);
					error_count++;
				end else begin
					out_item_t exp_r;
					exp_r = expected_results.pop_front();
					if (out_ch.data.sample_ratio !== exp_r.sample_ratio) begin
						$error("sample_ratio expected %0d actual %0d",
							exp_r.sample_ratio, out_ch.data.sample_ratio);
						error_count++;
					end
					if (out_ch.data.block_done !== exp_r.block_done) begin
						$error("block_done expected %0d actual %0d",
							exp_r.block_done, out_ch.data.block_done);
						error_count++;
					end
					if (out_ch.data.trimmed_mean !== exp_r.trimmed_mean) begin
						$error("trimmed_mean expected %0d actual %0d",
							exp_r.trimmed_mean, out_ch.data.trimmed_mean);
						error_count++;
					end
					if (out_ch.data.filtered_ratio !== exp_r.filtered_ratio) begin
						$error("filtered_ratio expected %0d actual %0d",
							exp_r.filtered_ratio, out_ch.data.filtered_ratio);
						error_count++;
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("ratio_trimmed_mean_filter test failed");
			$finish;
		end
	end

	initial begin
		in_item_t it;
		error_count = 0;
		idle_cycles = 0;
		stimulus_done = 0;
		block_pos = 0;
		history_pos = 0;
		history_fill = 0;
		held_trimmed = '0;
		held_filtered = '0;
		arst_n = 1'b0;

		for (int a = 0; a < 4; a++)
			for (int b = 0; b < 4; b++) begin
				it.chan_a_high = edge_code(a);
				it.chan_a_low = edge_code(3 - a);
				it.chan_b_high = edge_code(b);
				it.chan_b_low = edge_code((b + 1) % 4);
				pending_items.push_back(it);
			end
		// zero divisor with either sign of A, saturating full-scale ratios and small ones
		pending_items.push_back('{16'sd100, 16'sd0, 16'sd7, 16'sd7});
		pending_items.push_back('{16'sd0, 16'sd100, 16'sd7, 16'sd7});
		pending_items.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
		pending_items.push_back('{16'sh7FFF, 16'sh8000, 16'sd1, 16'sd0});
		pending_items.push_back('{16'sh8000, 16'sh7FFF, 16'sd1, 16'sd0});
		pending_items.push_back('{16'sd10, 16'sd0, 16'sd10, 16'sd0});
		pending_items.push_back('{16'sd1, 16'sd0, 16'sh7FFF, 16'sh8000});
		pending_items.push_back('{16'sd0, 16'sd1, 16'sd3, 16'sd0});
		for (int n = 0; n < 1530; n++)
			pending_items.push_back(random_item());

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_items.size() == 0);
		wait (expected_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0)
			$display("ratio_trimmed_mean_filter test passed");
		else
			$display("ratio_trimmed_mean_filter test failed");
		$finish;
	end
endmodule
